@@ rtl/core/ffha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes of the first-fit heap allocator.
// Used by the interfaces, the controller, the datapath and the top level.
package ffha_pkg;

   // Chunk table geometry and heap layout.
   localparam int MAX_CHUNKS   = 64;
   localparam int IDX_W        = $clog2(MAX_CHUNKS);
   localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 12;
   localparam int CSR_INDEX_W  = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_BASE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_LIMIT = CSR_INDEX_W'(1);

   localparam logic [31:0] HEAP_LIMIT_RESET = 32'd1048576;

   // Operation codes of the request channel.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NULL     = 3'd1,
      ST_OOM      = 3'd2,
      ST_FULL     = 3'd3,
      ST_UNKNOWN  = 3'd4,
      ST_OVERSIZE = 3'd5
   } status_type;

   // One chunk table entry.
   typedef struct packed {
      logic        is_free;
      logic [31:0] offset;
      logic [31:0] payload;
   } chunk_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_IDX_INC,
      OP_SPLIT_START,
      OP_SU_MOVE,
      OP_INSERT,
      OP_TAKE_SPLIT,
      OP_TAKE_WHOLE,
      OP_GROW,
      OP_MARK_FREE,
      OP_MERGE,
      OP_SD_MOVE,
      OP_SD_END,
      OP_MERGE_NEXT,
      OP_TRIM_SET,
      OP_TRIM,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_st;
      status_type st;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free_cmd;
      logic arg_zero;
      logic oversize;
      logic idx_end;
      logic idx_last;
      logic fit;
      logic split_ok;
      logic table_full;
      logic grow_oom;
      logic match;
      logic mergeable;
      logic ptr_gt_idx;
      logic ptr_lt_count;
      logic count_zero;
      logic trim_ok;
   } dp_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_A_RD,
      S_A_EV,
      S_SU_RD,
      S_SU_WR,
      S_A_INS,
      S_A_TAKE_S,
      S_A_GROW,
      S_F_RD,
      S_F_EV,
      S_M_RD,
      S_M_EV,
      S_SD_RD,
      S_SD_WR,
      S_T_SET,
      S_T_RD,
      S_T_EV,
      S_RESP
   } state_type;

endpackage

@@ rtl/core/ffha_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on ffha_pkg for the register index width.

interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] request_size;
   logic [31:0] payload_addr;
   modport source (output valid, cmd, request_size, payload_addr, input ready);
   modport sink   (input valid, cmd, request_size, payload_addr, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_addr;
   logic [2:0]  status;
   logic [31:0] break_addr;
   modport source (output valid, result_addr, status, break_addr, input ready);
   modport sink   (input valid, result_addr, status, break_addr, output ready);
endinterface

interface ffha_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ffha_pkg::CSR_INDEX_W-1:0]  reg_index;
   logic [31:0]                       write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

@@ rtl/core/ffha_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the allocator: sequences scans, shifts, merges and trims.
// Depends on ffha_pkg; drives the datapath only through command and status structs.
module ffha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffha_pkg::dp_sts_type sts,
   output ffha_pkg::dp_cmd_type cmd
);

   ffha_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   // A request may enter once the response slot is empty or emptying.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid && slot_free) state_in = ffha_pkg::S_CHECK;
         end
         ffha_pkg::S_CHECK: begin
            if (sts.arg_zero) state_in = ffha_pkg::S_RESP;
            else if (sts.is_free_cmd) state_in = ffha_pkg::S_F_RD;
            else if (sts.oversize) state_in = ffha_pkg::S_RESP;
            else state_in = ffha_pkg::S_A_RD;
         end
         ffha_pkg::S_A_RD: begin
            state_in = sts.idx_end ? ffha_pkg::S_A_GROW : ffha_pkg::S_A_EV;
         end
         ffha_pkg::S_A_EV: begin
            if (!sts.fit) state_in = ffha_pkg::S_A_RD;
            else if (sts.split_ok) state_in = ffha_pkg::S_SU_RD;
            else state_in = ffha_pkg::S_RESP;
         end
         ffha_pkg::S_SU_RD: begin
            state_in = sts.ptr_gt_idx ? ffha_pkg::S_SU_WR : ffha_pkg::S_A_INS;
         end
         ffha_pkg::S_SU_WR:    state_in = ffha_pkg::S_SU_RD;
         ffha_pkg::S_A_INS:    state_in = ffha_pkg::S_A_TAKE_S;
         ffha_pkg::S_A_TAKE_S: state_in = ffha_pkg::S_RESP;
         ffha_pkg::S_A_GROW:   state_in = ffha_pkg::S_RESP;
         ffha_pkg::S_F_RD: begin
            state_in = sts.idx_end ? ffha_pkg::S_RESP : ffha_pkg::S_F_EV;
         end
         ffha_pkg::S_F_EV: begin
            state_in = sts.match ? ffha_pkg::S_M_RD : ffha_pkg::S_F_RD;
         end
         ffha_pkg::S_M_RD: begin
            state_in = sts.idx_last ? ffha_pkg::S_T_SET : ffha_pkg::S_M_EV;
         end
         ffha_pkg::S_M_EV: begin
            state_in = sts.mergeable ? ffha_pkg::S_SD_RD : ffha_pkg::S_M_RD;
         end
         ffha_pkg::S_SD_RD: begin
            state_in = sts.ptr_lt_count ? ffha_pkg::S_SD_WR : ffha_pkg::S_M_RD;
         end
         ffha_pkg::S_SD_WR: state_in = ffha_pkg::S_SD_RD;
         ffha_pkg::S_T_SET: begin
            state_in = sts.count_zero ? ffha_pkg::S_RESP : ffha_pkg::S_T_RD;
         end
         ffha_pkg::S_T_RD: state_in = ffha_pkg::S_T_EV;
         ffha_pkg::S_T_EV: begin
            state_in = sts.trim_ok ? ffha_pkg::S_T_SET : ffha_pkg::S_RESP;
         end
         ffha_pkg::S_RESP: state_in = ffha_pkg::S_IDLE;
         default:          state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // Outputs: datapath command and request handshake.
   always_comb begin
      cmd.op     = ffha_pkg::OP_NOP;
      cmd.set_st = 1'b0;
      cmd.st     = ffha_pkg::ST_OK;
      req_ready  = 1'b0;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) cmd.op = ffha_pkg::OP_LOAD;
         end
         ffha_pkg::S_CHECK: begin
            if (sts.arg_zero) begin
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_NULL;
            end else if (!sts.is_free_cmd && sts.oversize) begin
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_OVERSIZE;
            end
         end
         ffha_pkg::S_A_EV: begin
            if (!sts.fit) begin
               cmd.op = ffha_pkg::OP_IDX_INC;
            end else if (sts.split_ok) begin
               cmd.op = ffha_pkg::OP_SPLIT_START;
            end else begin
               cmd.op     = ffha_pkg::OP_TAKE_WHOLE;
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_SU_WR: cmd.op = ffha_pkg::OP_SU_MOVE;
         ffha_pkg::S_A_INS: cmd.op = ffha_pkg::OP_INSERT;
         ffha_pkg::S_A_TAKE_S: begin
            cmd.op     = ffha_pkg::OP_TAKE_SPLIT;
            cmd.set_st = 1'b1;
            cmd.st     = ffha_pkg::ST_OK;
         end
         ffha_pkg::S_A_GROW: begin
            cmd.set_st = 1'b1;
            if (sts.table_full) begin
               cmd.st = ffha_pkg::ST_FULL;
            end else if (sts.grow_oom) begin
               cmd.st = ffha_pkg::ST_OOM;
            end else begin
               cmd.op = ffha_pkg::OP_GROW;
               cmd.st = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_F_RD: begin
            if (sts.idx_end) begin
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_UNKNOWN;
            end
         end
         ffha_pkg::S_F_EV: begin
            cmd.op = sts.match ? ffha_pkg::OP_MARK_FREE : ffha_pkg::OP_IDX_INC;
         end
         ffha_pkg::S_M_EV: begin
            cmd.op = sts.mergeable ? ffha_pkg::OP_MERGE : ffha_pkg::OP_MERGE_NEXT;
         end
         ffha_pkg::S_SD_RD: begin
            if (!sts.ptr_lt_count) cmd.op = ffha_pkg::OP_SD_END;
         end
         ffha_pkg::S_SD_WR: cmd.op = ffha_pkg::OP_SD_MOVE;
         ffha_pkg::S_T_SET: begin
            if (sts.count_zero) begin
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_OK;
            end else begin
               cmd.op = ffha_pkg::OP_TRIM_SET;
            end
         end
         ffha_pkg::S_T_EV: begin
            if (sts.trim_ok) begin
               cmd.op = ffha_pkg::OP_TRIM;
            end else begin
               cmd.set_st = 1'b1;
               cmd.st     = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_RESP: cmd.op = ffha_pkg::OP_FINISH;
         default: cmd.op = ffha_pkg::OP_NOP;
      endcase
   end

   // The response becomes valid once the finishing state registers it, and stays valid until it is taken.
   always_comb begin
      if (state_ff == ffha_pkg::S_RESP) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/ffha_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the allocator: chunk table memory, heap registers and compares.
// Depends on ffha_pkg; executes one command from the controller per cycle.
module ffha_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ffha_pkg::dp_cmd_type                cmd,
   output ffha_pkg::dp_sts_type                sts,
   input  logic                                req_cmd,
   input  logic [31:0]                         req_size,
   input  logic [31:0]                         req_addr,
   input  logic                                csr_we,
   input  logic [ffha_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data,
   output logic [31:0]                         rsp_addr,
   output logic [2:0]                          rsp_status,
   output logic [31:0]                         rsp_break
);

   localparam int IW = ffha_pkg::IDX_W;
   localparam int CW = ffha_pkg::CNT_W;
   localparam logic [31:0] HDR  = 32'(ffha_pkg::HEADER_BYTES);
   localparam logic [33:0] AMSK = 34'(ffha_pkg::ALIGN_BYTES - 1);

   // Chunk table memory with two registered read ports.
   ffha_pkg::chunk_type mem_ff [ffha_pkg::MAX_CHUNKS];
   ffha_pkg::chunk_type rd_a_ff, rd_b_ff;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   ffha_pkg::chunk_type mem_wdata;

   logic [31:0] base_ff, base_in, limit_ff, limit_in, top_ff, top_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, ptr_ff, ptr_in;
   logic [31:0] size_ff, size_in, addr_ff, addr_in;
   logic        free_cmd_ff, free_cmd_in, zero_ff, zero_in, over_ff, over_in;
   logic [31:0] res_addr_ff, res_addr_in;
   ffha_pkg::status_type res_st_ff, res_st_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in, rsp_brk_ff, rsp_brk_in;
   ffha_pkg::status_type rsp_st_ff, rsp_st_in;

   logic [33:0] req_round;
   logic [32:0] total, trim_total;
   logic [31:0] used, remain, payload_addr;

   // Request size rounded up to the alignment, kept wide for the size checks.
   assign req_round = ({2'b00, req_size} + AMSK) & ~AMSK;

   // Shared arithmetic on the current entry.
   assign used         = top_ff - base_ff;
   assign total        = {1'b0, size_ff} + {1'b0, HDR};
   assign remain       = rd_a_ff.payload - size_ff;
   assign trim_total   = {1'b0, rd_a_ff.payload} + {1'b0, HDR};
   assign payload_addr = base_ff + rd_a_ff.offset + HDR;

   // Status toward the controller.
   always_comb begin
      sts.is_free_cmd  = free_cmd_ff;
      sts.arg_zero     = zero_ff;
      sts.oversize     = over_ff;
      sts.idx_end      = idx_ff >= count_ff;
      sts.idx_last     = (idx_ff + CW'(1)) >= count_ff;
      sts.fit          = rd_a_ff.is_free && (rd_a_ff.payload >= size_ff);
      sts.split_ok     = (remain > 32'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES))
                         && (count_ff < CW'(ffha_pkg::MAX_CHUNKS));
      sts.table_full   = count_ff >= CW'(ffha_pkg::MAX_CHUNKS);
      sts.grow_oom     = (({2'b00, used} + {1'b0, total}) > {2'b00, limit_ff})
                         || (({2'b00, top_ff} + {1'b0, total}) > 34'h0_ffff_ffff);
      sts.match        = payload_addr == addr_ff;
      sts.mergeable    = rd_a_ff.is_free && rd_b_ff.is_free
                         && ((rd_a_ff.offset + HDR + rd_a_ff.payload) == rd_b_ff.offset);
      sts.ptr_gt_idx   = ptr_ff > idx_ff;
      sts.ptr_lt_count = ptr_ff < count_ff;
      sts.count_zero   = count_ff == '0;
      sts.trim_ok      = rd_a_ff.is_free
                         && (({2'b00, rd_a_ff.offset} + {1'b0, trim_total}) == {2'b00, used})
                         && (trim_total <= 33'h0_7fff_ffff);
   end

   // Command execution: register updates and the table write port.
   always_comb begin
      base_in     = base_ff;
      limit_in    = limit_ff;
      top_in      = top_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      free_cmd_in = free_cmd_ff;
      zero_in     = zero_ff;
      over_in     = over_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_brk_in  = rsp_brk_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff[IW-1:0];
      mem_wdata   = rd_a_ff;

      case (cmd.op)
         ffha_pkg::OP_LOAD: begin
            size_in     = req_round[31:0];
            addr_in     = req_addr;
            free_cmd_in = req_cmd == ffha_pkg::CMD_FREE;
            zero_in     = (req_cmd == ffha_pkg::CMD_FREE) ? (req_addr == '0)
                                                           : (req_size == '0);
            over_in     = (req_round + 34'(ffha_pkg::HEADER_BYTES)) > 34'h0_7fff_ffff;
            idx_in      = '0;
            res_addr_in = '0;
         end
         ffha_pkg::OP_IDX_INC: idx_in = idx_ff + CW'(1);
         ffha_pkg::OP_SPLIT_START: ptr_in = count_ff - CW'(1);
         ffha_pkg::OP_SU_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(ptr_ff + CW'(1));
            mem_wdata = rd_b_ff;
            ptr_in    = ptr_ff - CW'(1);
         end
         ffha_pkg::OP_INSERT: begin
            mem_we            = 1'b1;
            mem_waddr         = IW'(idx_ff + CW'(1));
            mem_wdata.is_free = 1'b1;
            mem_wdata.offset  = rd_a_ff.offset + HDR + size_ff;
            mem_wdata.payload = remain - HDR;
            count_in          = count_ff + CW'(1);
         end
         ffha_pkg::OP_TAKE_SPLIT: begin
            mem_we            = 1'b1;
            mem_wdata.is_free = 1'b0;
            mem_wdata.payload = size_ff;
            res_addr_in       = payload_addr;
         end
         ffha_pkg::OP_TAKE_WHOLE: begin
            mem_we            = 1'b1;
            mem_wdata.is_free = 1'b0;
            res_addr_in       = payload_addr;
         end
         ffha_pkg::OP_GROW: begin
            mem_we            = 1'b1;
            mem_waddr         = count_ff[IW-1:0];
            mem_wdata.is_free = 1'b0;
            mem_wdata.offset  = used;
            mem_wdata.payload = size_ff;
            count_in          = count_ff + CW'(1);
            top_in            = top_ff + total[31:0];
            res_addr_in       = base_ff + used + HDR;
         end
         ffha_pkg::OP_MARK_FREE: begin
            mem_we            = 1'b1;
            mem_wdata.is_free = 1'b1;
            idx_in            = '0;
            ptr_in            = CW'(1);
         end
         ffha_pkg::OP_MERGE: begin
            mem_we            = 1'b1;
            mem_wdata.payload = rd_a_ff.payload + HDR + rd_b_ff.payload;
            ptr_in            = idx_ff + CW'(2);
         end
         ffha_pkg::OP_SD_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(ptr_ff - CW'(1));
            mem_wdata = rd_b_ff;
            ptr_in    = ptr_ff + CW'(1);
         end
         ffha_pkg::OP_SD_END: begin
            count_in = count_ff - CW'(1);
            ptr_in   = idx_ff + CW'(1);
         end
         ffha_pkg::OP_MERGE_NEXT: begin
            idx_in = idx_ff + CW'(1);
            ptr_in = idx_ff + CW'(2);
         end
         ffha_pkg::OP_TRIM_SET: idx_in = count_ff - CW'(1);
         ffha_pkg::OP_TRIM: begin
            top_in   = top_ff - trim_total[31:0];
            count_in = count_ff - CW'(1);
         end
         ffha_pkg::OP_FINISH: begin
            rsp_addr_in = res_addr_ff;
            rsp_st_in   = res_st_ff;
            rsp_brk_in  = top_ff;
         end
         default: begin
         end
      endcase

      if (cmd.set_st) res_st_in = cmd.st;

      // Register writes must arrive only while the block is idle; the block does not enforce this.
      if (csr_we) begin
         case (csr_index)
            ffha_pkg::CSR_HEAP_BASE: begin
               base_in  = csr_data;
               top_in   = csr_data;
               count_in = '0;
            end
            ffha_pkg::CSR_HEAP_LIMIT: limit_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Table memory: one write and two registered reads per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_a_ff <= mem_ff[idx_ff[IW-1:0]];
      rd_b_ff <= mem_ff[ptr_ff[IW-1:0]];
   end

   // Heap control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= ffha_pkg::HEAP_LIMIT_RESET;
         top_ff   <= '0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      free_cmd_ff <= free_cmd_in;
      zero_ff     <= zero_in;
      over_ff     <= over_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_brk_ff  <= rsp_brk_in;
   end

   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_break  = rsp_brk_ff;

endmodule

@@ rtl/core/first_fit_heap_allocator_core.sv @@
`timescale 1ns / 1ps
// First-fit heap allocator over an address-ordered table of 64 chunks.
// Request channel req_chan: cmd (0 allocate, 1 free), request_size, payload_addr.
// Response channel rsp_chan: result_addr, status, break_addr; one response per request.
// Register channel csr_chan: index 0 heap_base (rebases and empties the table),
// index 1 heap_limit. It is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. One request is worked at a time.
// Every table entry visited takes a read state and then an evaluate or write state,
// through the table memory's registered read ports: the first-fit scan, the shift
// that opens a slot for a split, the free scan, the merge pass and the compaction
// after each merge. Each trimmed tail chunk takes a set, a read and an evaluate state.
// The next request is taken in the cycle after the response is registered,
// provided the response register is empty or is being read.
// Reset: empty table, break at address 0, heap_limit 1048576; the table memory
// is not cleared, since only entries below the fill count are ever read.
// A stalled receiver holds the response in its register, and the request
// channel stays closed until that response is taken.
module first_fit_heap_allocator_core (
   input  logic       clock,
   input  logic       reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan,
   ffha_csr_if.sink   csr_chan
);

   ffha_pkg::dp_cmd_type cmd;
   ffha_pkg::dp_sts_type sts;
   logic                 req_ready;

   // Register writes complete in the cycle they are offered.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffha_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_cmd    (req_chan.cmd),
      .req_size   (req_chan.request_size),
      .req_addr   (req_chan.payload_addr),
      .csr_we     (csr_chan.valid),
      .csr_index  (csr_chan.reg_index),
      .csr_data   (csr_chan.write_data),
      .rsp_addr   (rsp_chan.result_addr),
      .rsp_status (rsp_chan.status),
      .rsp_break  (rsp_chan.break_addr)
   );

endmodule

@@ rtl/core/ffha_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the allocator's request and response channels.
// Depends on ffha_pkg for status codes; bound to first_fit_heap_allocator_core.
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] result_addr,
   input logic [2:0]  status
);

   // A pending response stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   // Only defined status codes appear.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status <= 3'(ffha_pkg::ST_OVERSIZE)))
      else $error("undefined status code on the response");

   // A failed transaction grants no address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != 3'(ffha_pkg::ST_OK)) |-> (result_addr == '0))
      else $error("address granted with a failing status");

   // One request at a time: acceptance closes the request channel.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .result_addr (rsp_chan.result_addr),
   .status      (rsp_chan.status)
);
